// ===== sv/stoi_pkg.sv =====
// Package for the string-to-integer parser: widths, character codes,
// parse phases and the configuration bundle. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stoi_pkg;

    localparam int MAX_SYMBOLS = 16;
    localparam int SYM_W       = 8;
    localparam int SYM_IDX_W   = $clog2(MAX_SYMBOLS);
    localparam int COUNT_W     = 5;
    localparam int VALUE_W     = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;

    localparam logic [SYM_W-1:0] CH_NUL   = 8'd0;
    localparam logic [SYM_W-1:0] CH_TAB   = 8'd9;
    localparam logic [SYM_W-1:0] CH_CR    = 8'd13;
    localparam logic [SYM_W-1:0] CH_SPACE = 8'd32;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'd45;
    localparam logic [SYM_W-1:0] CH_DEL   = 8'd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYMBOLS_LOW  = 2'd0,
        REG_SYMBOLS_HIGH = 2'd1,
        REG_SYMBOL_COUNT = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        PH_SPACE  = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    // Alphabet as seen by the datapath, plus its validity flag.
    typedef struct packed {
        logic [MAX_SYMBOLS-1:0][SYM_W-1:0] symbols;
        logic [COUNT_W-1:0]                count;
        logic                              ok;
    } cfg_t;

    function automatic logic is_space(input logic [SYM_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

`default_nettype wire

// ===== sv/string_to_integer_any_radix_core.sv =====
// Top level of the string-to-integer parser with a configurable alphabet.
// Depends on stoi_pkg, stoi_cfg and stoi_parse.
//
//   Channel   Direction  Handshake              Beat contents
//   input     in         in_valid / in_stall    char_code, last_char
//   result    out        out_valid / out_stall  value, base_ok
//   config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low. A byte is held in the input
// register, where the lookup and the multiply-add update the parse state, and a
// final byte then loads the result register, so a result passes through the
// input register and then the result register. The rate is set by the parse-state
// loop. Reset is asynchronous and active low; it empties both registers and
// clears the alphabet. A held result stalls the input only when the staged byte
// is itself a final byte.
`timescale 1ns / 1ps
`default_nettype none

module string_to_integer_any_radix_core
    import stoi_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [SYM_W-1:0]      char_code,
    input  wire logic                  last_char,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic signed [VALUE_W-1:0]  value,
    output logic                       base_ok,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t               cfg;
    logic               out_free;
    logic               res_fire;
    logic [VALUE_W-1:0] res_value;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [VALUE_W-1:0] value_reg;
    logic               base_ok_reg;

    // Register writes are always taken; the user must write only while the block is idle, which it does not enforce.
    assign cfg_ready = 1'b1;

    stoi_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    stoi_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .last_char (last_char),
        .cfg       (cfg),
        .out_free  (out_free),
        .res_fire  (res_fire),
        .res_value (res_value)
    );

    // The result register can take a new beat when it is empty or its
    // current beat leaves at this edge.
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // An invalid alphabet forces the value to zero.
    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            value_reg   <= cfg.ok ? res_value : '0;
            base_ok_reg <= cfg.ok;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = $signed(value_reg);
    assign base_ok   = base_ok_reg;

endmodule

`default_nettype wire

// ===== sv/stoi_cfg.sv =====
// Configuration registers for the parser alphabet and the alphabet check.
// Depends on stoi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stoi_cfg
    import stoi_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    logic [CFG_DATA_W-1:0] sym_low_reg;
    logic [CFG_DATA_W-1:0] sym_high_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic                  ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_low_reg  <= '0;
            sym_high_reg <= '0;
            count_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_SYMBOLS_LOW:  sym_low_reg  <= cfg_data;
                REG_SYMBOLS_HIGH: sym_high_reg <= cfg_data;
                REG_SYMBOL_COUNT: count_reg    <= cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // The alphabet is valid when it has 2 to MAX_SYMBOLS printable symbols,
    // none of them a sign character and no two alike.
    always_comb
    begin
        logic [MAX_SYMBOLS-1:0][SYM_W-1:0] syms;
        syms = {sym_high_reg, sym_low_reg};
        ok   = (count_reg >= COUNT_W'(2)) && (count_reg <= COUNT_W'(MAX_SYMBOLS));
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            if (COUNT_W'(i) < count_reg)
            begin
                if ((syms[i] < CH_SPACE) || (syms[i] >= CH_DEL) ||
                    (syms[i] == CH_PLUS) || (syms[i] == CH_MINUS))
                begin
                    ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++)
                begin
                    if ((COUNT_W'(j) < count_reg) && (syms[i] == syms[j]))
                    begin
                        ok = 1'b0;
                    end
                end
            end
        end
        cfg.symbols = syms;
        cfg.count   = count_reg;
        cfg.ok      = ok;
    end

endmodule

`default_nettype wire

// ===== sv/stoi_parse.sv =====
// Input register and per-byte parse state: whitespace, sign and digit
// accumulation. Depends on stoi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stoi_parse
    import stoi_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [SYM_W-1:0]   char_code,
    input  wire logic               last_char,
    input  wire cfg_t               cfg,
    input  wire logic               out_free,
    output logic                    res_fire,
    output logic [VALUE_W-1:0]      res_value
);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [SYM_W-1:0]   s1_char_reg;
    logic               s1_last_reg;
    logic               advance;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic               neg_reg;
    logic               neg_next;
    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] acc_next;

    logic               hit;
    logic [SYM_IDX_W-1:0] hit_idx;
    logic [VALUE_W-1:0] product;

    // The staged byte moves on unless it ends a string and the result
    // register is still held.
    assign advance   = !s1_valid_reg || !s1_last_reg || out_free;
    assign in_stall  = !advance;
    assign res_fire  = s1_valid_reg && s1_last_reg && advance;

    assign s1_valid_next = in_valid ? 1'b1 : (s1_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && advance)
        begin
            s1_char_reg <= char_code;
            s1_last_reg <= last_char;
        end
    end

    // First matching symbol among those in use; lower indexes win.
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = MAX_SYMBOLS - 1; i >= 0; i--)
        begin
            if ((COUNT_W'(i) < cfg.count) && (cfg.symbols[i] == s1_char_reg))
            begin
                hit     = 1'b1;
                hit_idx = SYM_IDX_W'(i);
            end
        end
    end

    assign product = acc_reg * {{(VALUE_W-COUNT_W){1'b0}}, cfg.count};

    always_comb
    begin
        phase_t             ph;
        logic               ng;
        logic [VALUE_W-1:0] ac;
        ph = phase_reg;
        ng = neg_reg;
        ac = acc_reg;
        if ((ph == PH_SPACE) && !is_space(s1_char_reg))
        begin
            ph = PH_SIGN;
        end
        if (ph == PH_SIGN)
        begin
            if (s1_char_reg == CH_MINUS)
            begin
                ng = ~ng;
            end
            else if (s1_char_reg != CH_PLUS)
            begin
                ph = PH_DIGITS;
            end
        end
        if (ph == PH_DIGITS)
        begin
            if (hit && (s1_char_reg != CH_NUL))
            begin
                ac = product + {{(VALUE_W-SYM_IDX_W){1'b0}}, hit_idx};
            end
            else
            begin
                ph = PH_DONE;
            end
        end

        res_value = ng ? (VALUE_W'(0) - ac) : ac;

        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        if (s1_valid_reg && advance)
        begin
            if (s1_last_reg)
            begin
                phase_next = PH_SPACE;
                neg_next   = 1'b0;
                acc_next   = '0;
            end
            else
            begin
                phase_next = ph;
                neg_next   = ng;
                acc_next   = ac;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SPACE;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/string_to_integer_any_radix_core_test.sv =====
// Self-checking testbench for string_to_integer_any_radix_core: a directed script
// and random alphabet phases, checked against a behavioral parser kept in this file.
// Depends on stoi_pkg and the core RTL.
`timescale 1ns / 1ps

module string_to_integer_any_radix_core_test;
    import stoi_pkg::*;

    localparam int HALF_PERIOD          = 6;
    localparam int RESET_CYCLES         = 4;
    localparam int MAX_WAIT             = 11;
    localparam int LONG_HOLD            = 300;
    localparam int SETTLE_CYCLES        = 4;
    localparam int STUCK_LIMIT          = 2000;
    localparam int TARGET_CHARS         = 1480;
    localparam int STRINGS_PER_ALPHABET = 12;
    localparam int SCRIPT_LEN           = 33;

    // Index 3 maps to no register; writes there must leave the alphabet alone.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Ways a random alphabet can be made wrong on purpose.
    typedef enum int {AB_VALID, AB_BAD_COUNT, AB_DUPLICATE, AB_BAD_BYTE} alphabet_flaw_t;

    typedef enum logic {ROW_CFG, ROW_CHAR} row_kind_t;

    // One input beat, optionally carrying a hand-typed expectation for its string.
    typedef struct {
        logic [SYM_W-1:0]          ch;
        logic                      last;
        logic                      typed;
        logic signed [VALUE_W-1:0] want_value;
        logic                      want_ok;
    } char_beat_t;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      ok;
    } parse_result_t;

    typedef struct {
        row_kind_t                 kind;
        logic [SYM_W-1:0]          ch;
        logic                      last;
        logic                      typed;
        logic signed [VALUE_W-1:0] want_value;
        logic                      want_ok;
        logic [CFG_IDX_W-1:0]      idx;
        logic [CFG_DATA_W-1:0]     data;
    } script_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [SYM_W-1:0]          char_code = '0;
    logic                      last_char = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [VALUE_W-1:0] value;
    logic                      base_ok;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;

    // Beats waiting to be offered, and results the parser still owes us, oldest first.
    char_beat_t    char_q[$];
    parse_result_t result_q[$];

    // Handshake bookkeeping shared between the processes.
    bit          driver_busy = 1'b0;
    bit          sender_gaps = 1'b1;
    bit          receiver_stalls = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned beat_count = 0;
    int          errors = 0;

    // Behavioral copy of the alphabet registers and the parse state.
    logic [CFG_DATA_W-1:0] alpha_lo = '0;
    logic [CFG_DATA_W-1:0] alpha_hi = '0;
    logic [COUNT_W-1:0]    alpha_count = '0;
    phase_t                parse_ph = PH_SPACE;
    logic                  negative = 1'b0;
    logic [VALUE_W-1:0]    acc = '0;

    // Directed script. Rows with typed set carry an expectation that is obvious
    // from the spec; every other final byte is checked against the parser model.
    script_row_t script [SCRIPT_LEN] = '{
        // Straight out of reset the alphabet is empty, so the result is rejected.
        '{ROW_CHAR, "7", 1'b1, 1'b1, '0, 1'b0, REG_SPARE, '0},
        // Decimal: symbols '0'..'9' in slots 0..9, with 'A'..'F' parked above.
        '{ROW_CFG, CH_NUL, 1'b0, 1'b0, '0, 1'b0, REG_SYMBOLS_LOW, 64'h3736_3534_3332_3130},
        '{ROW_CFG, CH_NUL, 1'b0, 1'b0, '0, 1'b0, REG_SYMBOLS_HIGH, 64'h4645_4443_4241_3938},
        '{ROW_CFG, CH_NUL, 1'b0, 1'b0, '0, 1'b0, REG_SYMBOL_COUNT, 64'd10},
        // Whitespace, a folded sign run, digits, then a stray symbol after the run.
        '{ROW_CHAR, CH_SPACE, 1'b0, 1'b0, '0, 1'b0, REG_SPARE, '0},
        '{ROW_CHAR, CH_TAB, 1'b0, 1'b0, '0, 1'b0, REG_SPARE, '0},
        '{ROW_CHAR, CH_MINUS, 1'b0, 1'b0, '0, 1'b0, REG_SPARE, '0},
        '{ROW_CHAR, CH_PLUS, 1'b0, 1'b0, '0, 1'b0, REG_SPARE, '0},
        '{ROW_CHAR, CH_MINUS, 1'b0, 1'b0, '0, 1'b0, REG_SPARE, '0},
        '{ROW_CHAR, "4", 1'b0, 1'b0, '0, 1'b0, REG_SPARE, '0},
        '{ROW_CHAR, "2", 1'b0, 1'b0, '0, 1'b0, REG_SPARE, '0},
        '{ROW_CHAR, "x", 1'b0, 1'b0, '0, 1'b0, REG_SPARE, '0},
        '{ROW_CHAR, "9", 1'b1, 1'b0, '0, 1'b0, REG_SPARE, '0},
        // A NUL cuts the digit run short.
        '{ROW_CHAR, "5", 1'b0, 1'b0, '0, 1'b0, REG_SPARE, '0},
        '{ROW_CHAR, CH_NUL, 1'b0, 1'b0, '0, 1'b0, REG_SPARE, '0},
        '{ROW_CHAR, "3", 1'b1, 1'b0, '0, 1'b0, REG_SPARE, '0},
        // A lone NUL reads no digits at all.
        '{ROW_CHAR, CH_NUL, 1'b1, 1'b1, '0, 1'b1, REG_SPARE, '0},
        // Full sixteen-symbol hex alphabet.
        '{ROW_CFG, CH_NUL, 1'b0, 1'b0, '0, 1'b0, REG_SYMBOL_COUNT, 64'd16},
        '{ROW_CHAR, CH_MINUS, 1'b0, 1'b0, '0, 1'b0, REG_SPARE, '0},
        '{ROW_CHAR, "F", 1'b1, 1'b1, -32'sd15, 1'b1, REG_SPARE, '0},
        // A write to the unused index must not disturb anything.
        '{ROW_CFG, CH_NUL, 1'b0, 1'b0, '0, 1'b0, REG_SPARE, '1},
        '{ROW_CHAR, "1", 1'b0, 1'b0, '0, 1'b0, REG_SPARE, '0},
        '{ROW_CHAR, "0", 1'b1, 1'b0, '0, 1'b0, REG_SPARE, '0},
        // One symbol too many for the table.
        '{ROW_CFG, CH_NUL, 1'b0, 1'b0, '0, 1'b0, REG_SYMBOL_COUNT, 64'd17},
        '{ROW_CHAR, "1", 1'b1, 1'b1, '0, 1'b0, REG_SPARE, '0},
        // Smallest legal radix.
        '{ROW_CFG, CH_NUL, 1'b0, 1'b0, '0, 1'b0, REG_SYMBOL_COUNT, 64'd2},
        '{ROW_CHAR, "1", 1'b0, 1'b0, '0, 1'b0, REG_SPARE, '0},
        '{ROW_CHAR, "0", 1'b0, 1'b0, '0, 1'b0, REG_SPARE, '0},
        '{ROW_CHAR, "1", 1'b1, 1'b0, '0, 1'b0, REG_SPARE, '0},
        // Two equal symbols in use.
        '{ROW_CFG, CH_NUL, 1'b0, 1'b0, '0, 1'b0, REG_SYMBOLS_LOW, 64'h3736_3534_3332_3030},
        '{ROW_CHAR, "0", 1'b1, 1'b1, '0, 1'b0, REG_SPARE, '0},
        // A plus sign used as a digit symbol.
        '{ROW_CFG, CH_NUL, 1'b0, 1'b0, '0, 1'b0, REG_SYMBOLS_LOW, 64'h3736_3534_3332_312B},
        '{ROW_CHAR, "1", 1'b1, 1'b1, '0, 1'b0, REG_SPARE, '0}
    };

    string_to_integer_any_radix_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .base_ok   (base_ok),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------

    function automatic logic [SYM_W-1:0] symbol_at(input int k);
        if (k < 8)
            return alpha_lo[k*SYM_W +: SYM_W];
        else
            return alpha_hi[(k-8)*SYM_W +: SYM_W];
    endfunction

    // The alphabet is usable only with 2..16 distinct printable symbols,
    // none of which is a sign character.
    function automatic logic alphabet_valid();
        int n;
        n = alpha_count;
        if (n < 2 || n > MAX_SYMBOLS)
            return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (symbol_at(i) < CH_SPACE || symbol_at(i) >= CH_DEL ||
                symbol_at(i) == CH_PLUS || symbol_at(i) == CH_MINUS)
                return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (symbol_at(i) == symbol_at(j))
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // First slot holding c among the slots in use, or -1. Counts above the
    // table size still search the whole table.
    function automatic int symbol_index(input logic [SYM_W-1:0] c);
        int n;
        n = (alpha_count < MAX_SYMBOLS) ? int'(alpha_count) : MAX_SYMBOLS;
        for (int k = 0; k < n; k++)
            if (symbol_at(k) == c)
                return k;
        return -1;
    endfunction

    // One byte moves the parse through as many phases as it can in one go:
    // a non-blank byte leaves the whitespace phase and is looked at as a sign,
    // and a non-sign byte is looked at as a digit right away.
    function automatic void absorb_char(input logic [SYM_W-1:0] c);
        int idx;
        if (parse_ph == PH_SPACE && !(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)))
            parse_ph = PH_SIGN;
        if (parse_ph == PH_SIGN)
        begin
            if (c == CH_MINUS)
                negative = !negative;
            else if (c != CH_PLUS)
                parse_ph = PH_DIGITS;
        end
        if (parse_ph == PH_DIGITS)
        begin
            idx = symbol_index(c);
            if (idx >= 0 && c != CH_NUL)
                acc = acc * VALUE_W'(alpha_count) + VALUE_W'(idx);
            else
                parse_ph = PH_DONE;
        end
    endfunction

    // The final byte yields the result and rearms the parser for the next string.
    function automatic parse_result_t close_string();
        parse_result_t      r;
        logic [VALUE_W-1:0] signed_acc;
        signed_acc = negative ? (VALUE_W'(0) - acc) : acc;
        r.ok       = alphabet_valid();
        r.value    = r.ok ? signed_acc : '0;
        parse_ph   = PH_SPACE;
        negative   = 1'b0;
        acc        = '0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side: offers queued bytes with random gaps and runs the model on
    // every byte the core accepts. in_valid is only lowered when no byte
    // follows straight away, so a back-to-back beat never sees it dip.
    // ------------------------------------------------------------------
    initial
    begin : char_driver
        char_beat_t    b;
        parse_result_t r;
        int            gap;
        forever
        begin
            if (char_q.size() == 0)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                b = char_q.pop_front();
                driver_busy = 1'b1;
                gap = sender_gaps ? $urandom_range(0, MAX_WAIT) : 0;
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                in_valid  <= 1'b1;
                char_code <= b.ch;
                last_char <= b.last;
                do @(posedge clk); while (in_stall);
                beat_count++;
                absorb_char(b.ch);
                if (b.last)
                begin
                    r = close_string();
                    if (b.typed)
                        r = '{b.want_value, b.want_ok};
                    result_q.push_back(r);
                end
                driver_busy = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: stalls a random number of cycles before each beat, or for
    // one long stretch on request so that the core backs up into its input.
    // Outputs are read right after the edge, so they hold pre-edge values.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        parse_result_t want;
        int            hold;
        forever
        begin
            hold = receiver_stalls ? $urandom_range(0, MAX_WAIT) : 0;
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold = LONG_HOLD;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            beat_count++;
            if (result_q.size() == 0)
            begin
                $display("%0t: unexpected result beat, value %0d base_ok %0b",
                         $time, value, base_ok);
                errors++;
            end
            else
            begin
                want = result_q.pop_front();
                if (value !== want.value)
                begin
                    $display("%0t: value mismatch, expected %0d, actual %0d",
                             $time, want.value, value);
                    errors++;
                end
                if (base_ok !== want.ok)
                begin
                    $display("%0t: base_ok mismatch, expected %0b, actual %0b",
                             $time, want.ok, base_ok);
                    errors++;
                end
            end
        end
    end

    // Ends the run if no beat moves on any channel for too long.
    initial
    begin : watchdog
        int          stuck;
        int unsigned seen;
        stuck = 0;
        seen  = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if (beat_count != seen)
            begin
                seen  = beat_count;
                stuck = 0;
            end
            else
                stuck++;
        end
        $display("%0t: no beat for %0d cycles", $time, STUCK_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Configuration helpers
    // ------------------------------------------------------------------

    // Leaves cfg_valid high; the caller lowers it after the last write of a batch.
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        beat_count++;
        case (idx)
            REG_SYMBOLS_LOW:  alpha_lo = data;
            REG_SYMBOLS_HIGH: alpha_hi = data;
            REG_SYMBOL_COUNT: alpha_count = data[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    // Waits until every queued byte is taken and every result is back, then lets
    // the core settle so that nothing is still moving inside it.
    task automatic wait_quiet();
        while (char_q.size() != 0 || driver_busy || result_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Draws a random alphabet. Unused slots get arbitrary bytes; about three in
    // ten alphabets are spoiled by a bad count, a duplicate or a bad symbol.
    task automatic pick_alphabet(output logic [CFG_DATA_W-1:0] lo,
                                 output logic [CFG_DATA_W-1:0] hi,
                                 output logic [COUNT_W-1:0] n);
        logic [SYM_W-1:0] syms [MAX_SYMBOLS];
        bit               taken [256];
        logic [SYM_W-1:0] c;
        int               i;
        int               j;
        int               r;
        alphabet_flaw_t   flaw;
        for (int k = 0; k < MAX_SYMBOLS; k++)
            syms[k] = SYM_W'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0:       n = COUNT_W'(2);
            1:       n = COUNT_W'(MAX_SYMBOLS);
            default: n = COUNT_W'($urandom_range(2, MAX_SYMBOLS));
        endcase
        for (int k = 0; k < n; k++)
        begin
            do
                c = SYM_W'($urandom_range(32, 126));
            while (taken[c] || c == CH_PLUS || c == CH_MINUS);
            taken[c] = 1'b1;
            syms[k]  = c;
        end
        r = $urandom_range(0, 9);
        flaw = (r < 7) ? AB_VALID : alphabet_flaw_t'(r - 6);
        case (flaw)
            AB_BAD_COUNT:
                n = $urandom_range(0, 1) ? COUNT_W'($urandom_range(0, 1))
                                         : COUNT_W'($urandom_range(17, 31));
            AB_DUPLICATE:
            begin
                i = $urandom_range(1, n - 1);
                j = $urandom_range(0, i - 1);
                syms[i] = syms[j];
            end
            AB_BAD_BYTE:
            begin
                i = $urandom_range(0, n - 1);
                case ($urandom_range(0, 2))
                    0:       syms[i] = SYM_W'($urandom_range(0, 31));
                    1:       syms[i] = SYM_W'($urandom_range(127, 255));
                    default: syms[i] = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
                endcase
            end
            default: ;
        endcase
        for (int k = 0; k < 8; k++)
        begin
            lo[k*SYM_W +: SYM_W] = syms[k];
            hi[k*SYM_W +: SYM_W] = syms[k+8];
        end
    endtask

    // Queues one string for the current alphabet. Most strings are well formed:
    // blanks, a sign run, digits and sometimes a terminator with trailing junk.
    // The rest are random bytes. Every queued byte counts toward the total.
    task automatic queue_string(inout int chars_sent);
        logic [SYM_W-1:0] s[$];
        int               n_used;
        int               k;
        n_used = (alpha_count < MAX_SYMBOLS) ? int'(alpha_count) : MAX_SYMBOLS;
        if ($urandom_range(0, 6) == 0)
        begin
            repeat ($urandom_range(1, 8)) s.push_back(SYM_W'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 3))
            begin
                k = $urandom_range(0, 5);
                s.push_back((k == 5) ? CH_SPACE : SYM_W'(CH_TAB + k));
            end
            repeat ($urandom_range(0, 3))
                s.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            if (n_used > 0)
                repeat (($urandom_range(0, 4) == 0) ? $urandom_range(9, 12)
                                                    : $urandom_range(1, 6))
                    s.push_back(symbol_at($urandom_range(0, n_used - 1)));
            case ($urandom_range(0, 2))
                1:
                begin
                    s.push_back(CH_NUL);
                    repeat ($urandom_range(0, 3)) s.push_back(SYM_W'($urandom_range(0, 255)));
                end
                2:
                begin
                    s.push_back(SYM_W'($urandom_range(0, 255)));
                    repeat ($urandom_range(0, 2)) s.push_back(SYM_W'($urandom_range(0, 255)));
                end
                default: ;
            endcase
            if (s.size() == 0)
                s.push_back(CH_NUL);
        end
        for (k = 0; k < s.size(); k++)
            char_q.push_back('{s[k], (k == s.size() - 1), 1'b0, '0, 1'b0});
        chars_sent += s.size();
    endtask

    // ------------------------------------------------------------------
    // Stimulus: reset, the directed script, then random alphabet phases.
    // Registers are only written once the core has gone quiet.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [CFG_DATA_W-1:0] count_word;
        logic [COUNT_W-1:0]    n;
        int                    chars_sent;
        int                    phase_no;
        chars_sent = 0;
        phase_no   = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            if (script[i].kind == ROW_CFG)
            begin
                wait_quiet();
                reg_write(script[i].idx, script[i].data);
                cfg_valid <= 1'b0;
            end
            else
                char_q.push_back('{script[i].ch, script[i].last, script[i].typed,
                                   script[i].want_value, script[i].want_ok});
        end

        while (chars_sent < TARGET_CHARS)
        begin
            pick_alphabet(lo, hi, n);
            wait_quiet();
            if ($urandom_range(0, 3) == 0)
                reg_write(REG_SPARE, {$urandom, $urandom});
            reg_write(REG_SYMBOLS_LOW, lo);
            reg_write(REG_SYMBOLS_HIGH, hi);
            // Upper data bits are random; only the low five bits hold the count.
            count_word = {$urandom, $urandom};
            count_word[COUNT_W-1:0] = n;
            reg_write(REG_SYMBOL_COUNT, count_word);
            cfg_valid <= 1'b0;

            // One early phase runs the sender flat out while the receiver holds
            // off for a long stretch, so the core fills and stalls its input.
            if (phase_no == 2)
            begin
                sender_gaps  = 1'b0;
                hold_request = 1'b1;
            end
            else
                sender_gaps = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);

            repeat (STRINGS_PER_ALPHABET) queue_string(chars_sent);
            phase_no++;
        end

        wait_quiet();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
